@@ src/psg_pkg.sv @@
// shared constants, types and helpers for the tone generator and mixer
package psg_pkg;

  localparam int TONE_CHANNELS_DEF = 3;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int CHIP_CLOCK = 4000000;
  localparam int CHIP_DIV   = CHIP_CLOCK / 32;

  localparam int PERIOD_W       = 10;
  localparam int WHOLE_W        = 9;
  localparam int PHASE_W        = 10;
  localparam int VOL_W          = 7;
  localparam int ATTEN_W        = 4;
  localparam int RATE_W         = 16;
  localparam int TUNE_W         = 9;
  localparam int TUNE_FRAC_BITS = 8;
  localparam int DIVISOR_W      = 4;
  localparam int FREQ_W         = 17;
  localparam int HALF_VW        = FREQ_W + 1;
  localparam int TOTAL_W        = 10;
  localparam int MAG_W          = TOTAL_W - 3;
  localparam int SAMPLE_W       = 8;
  localparam int BYTE_W         = 8;
  localparam int LATCH_W        = 2;
  localparam int CODE_W         = 3;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [PERIOD_W-1:0]  PERIOD_RESET     = 10'd1000;
  localparam logic [PERIOD_W-1:0]  LEVEL_MODE_LIMIT = 10'd5;
  localparam logic [VOL_W-1:0]     VOLUME_RESET     = 7'd120;
  localparam logic [WHOLE_W-1:0]   WHOLE_MAX        = 9'd511;
  localparam logic [ATTEN_W-1:0]   ATTEN_OFF        = 4'd15;
  localparam logic [ATTEN_W-1:0]   ATTEN_MID        = 4'd7;
  localparam logic [CODE_W-1:0]    CODE_NOISE       = 3'd6;
  localparam logic [LATCH_W-1:0]   CODE_CH_TOP      = 2'd2;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MID       = 8'd128;
  localparam logic [DIVISOR_W-1:0] DIVISOR_ONE      = 4'd1;

  localparam logic [VOL_W-1:0] EXP_LEVELS [16] = '{
    7'd0, 7'd11, 7'd14, 7'd17, 7'd20, 7'd24, 7'd28, 7'd33,
    7'd39, 7'd46, 7'd54, 7'd63, 7'd74, 7'd87, 7'd102, 7'd120
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_RATE,
    REG_VOLUME_DIVISOR,
    REG_EXPONENTIAL_VOLUME,
    REG_FRACTIONAL_PERIODS,
    REG_TUNING_OFFSET
  } psg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HALF,
    ST_MIX,
    ST_DIV,
    ST_OUT
  } psg_state_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_DIV1,
    H_DIV2
  } psg_half_state_t;

  function automatic logic [VOL_W-1:0] level_of(input logic [ATTEN_W-1:0] v,
                                                input logic expo);
    level_of = expo ? EXP_LEVELS[v] : {v, 3'b000};
  endfunction

endpackage

@@ src/psg_if.sv @@
// valid/ready channel interfaces for commands, samples and configuration
interface psg_in_if import psg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] write_byte;

  modport source(output valid, output op, output write_byte, input ready);
  modport sink(input valid, input op, input write_byte, output ready);
endinterface

interface psg_out_if import psg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] audio_sample;

  modport source(output valid, output audio_sample, input ready);
  modport sink(input valid, input audio_sample, output ready);
endinterface

interface psg_cfg_if import psg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ src/psg_serial_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
module psg_serial_div import psg_pkg::*; #(
  parameter int DW = 8,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [VW-1:0]    rem;
  logic [VW-1:0]    dsr;
  logic [DW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [VW:0]      rem_sh;
  logic             fits;

  assign rem_sh   = {rem, quo[DW-1]};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= CNT_W'(DW);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (fits) begin
        rem <= VW'(rem_sh - {1'b0, dsr});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[VW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt == CNT_W'(1) |=> done)
    else $error("divider missed done after last step");

endmodule

@@ src/psg_half_calc.sv @@
// half-period sequencer: tone period to whole and fractional samples
module psg_half_calc import psg_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [PERIOD_W-1:0]      period,
  input  logic [RATE_W-1:0]        sample_rate,
  input  logic signed [TUNE_W-1:0] tuning,
  output logic                     done,
  output logic [WHOLE_W-1:0]       whole,
  output logic [FRACTION_BITS-1:0] frac,
  output logic                     level_mode
);

  localparam int DW = RATE_W + FRACTION_BITS;
  localparam int HW = DW + 2;
  localparam int WF = HW - FRACTION_BITS;

  psg_half_state_t     st, st_next;
  logic                div_start;
  logic                div_done;
  logic [DW-1:0]       div_dividend;
  logic [HALF_VW-1:0]  div_divisor;
  logic [DW-1:0]       div_q;
  logic [PERIOD_W-1:0] period_eff;
  logic signed [HW-1:0] h_sum;
  logic [HW-1:0]       h_clamp;
  logic [WF-1:0]       whole_full;
  logic                sat;

  psg_serial_div #(.DW(DW), .VW(HALF_VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign period_eff = (period == '0) ? PERIOD_W'(1) : period;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= H_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next      = st;
    div_start    = 1'b0;
    div_dividend = DW'(CHIP_DIV);
    div_divisor  = HALF_VW'(period_eff);
    case (st)
      H_IDLE: begin
        if (start) begin
          div_start = 1'b1;
          st_next   = H_DIV1;
        end
      end
      H_DIV1: begin
        div_dividend = {sample_rate, {FRACTION_BITS{1'b0}}};
        div_divisor  = {div_q[FREQ_W-1:0], 1'b0};
        if (div_done) begin
          div_start = 1'b1;
          st_next   = H_DIV2;
        end
      end
      H_DIV2: begin
        if (div_done) begin
          st_next = H_IDLE;
        end
      end
      default: st_next = H_IDLE;
    endcase
  end

  assign h_sum      = $signed({2'b00, div_q}) +
                      ($signed(HW'(tuning)) <<< (FRACTION_BITS - TUNE_FRAC_BITS));
  assign h_clamp    = h_sum[HW-1] ? '0 : h_sum;
  assign whole_full = h_clamp[HW-1:FRACTION_BITS];
  assign sat        = whole_full > WF'(WHOLE_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (st == H_DIV2) && div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      level_mode <= period_eff < LEVEL_MODE_LIMIT;
    end
    if (st == H_DIV2 && div_done) begin
      whole <= sat ? WHOLE_MAX : whole_full[WHOLE_W-1:0];
      frac  <= sat ? '1 : h_clamp[FRACTION_BITS-1:0];
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> st == H_IDLE)
    else $error("half-period start while busy");
  a_done_src: assert property (@(posedge clk) disable iff (rst) done |-> $past(st) == H_DIV2)
    else $error("half-period done outside second division");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (st == H_DIV1 || st == H_DIV2))
    else $error("divider done while sequencer idle");

endmodule

@@ src/psg_tone_register_and_mixer.sv @@
// tone register file, square-wave mixer and sample output stage
// period write transaction: two serial divisions in the half-period sequencer;
//   volume, noise and ignored writes are accepted while idle and start no division
// tick transaction: one channel per cycle, then a serial divide by the volume divisor;
//   the sample is loaded once the divide is done and the output register is free
// a finished sample waits in an output register; synchronous reset restores all defaults
module psg_tone_register_and_mixer import psg_pkg::*; #(
  parameter int TONE_CHANNELS = TONE_CHANNELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  psg_in_if.sink     cmd,
  psg_out_if.source  sample,
  psg_cfg_if.sink    cfg
);

  localparam int CH_W    = (TONE_CHANNELS > 1) ? $clog2(TONE_CHANNELS) : 1;
  localparam int CARRY_W = FRACTION_BITS + 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(TONE_CHANNELS - 1);

  // configuration
  logic [RATE_W-1:0]        sample_rate;
  logic [DIVISOR_W-1:0]     volume_divisor;
  logic                     exponential_volume;
  logic                     fractional_periods;
  logic signed [TUNE_W-1:0] tuning_offset;

  // channel state
  logic [PERIOD_W-1:0]      tone_period          [TONE_CHANNELS];
  logic [WHOLE_W-1:0]       half_period_whole    [TONE_CHANNELS];
  logic [FRACTION_BITS-1:0] half_period_fraction [TONE_CHANNELS];
  logic [CARRY_W-1:0]       fraction_carry       [TONE_CHANNELS];
  logic [PHASE_W-1:0]       phase_count          [TONE_CHANNELS];
  logic                     output_level         [TONE_CHANNELS];
  logic                     channel_active       [TONE_CHANNELS];
  logic                     level_mode           [TONE_CHANNELS];
  logic [VOL_W-1:0]         channel_volume       [TONE_CHANNELS];
  logic [LATCH_W-1:0]       latched_channel;

  psg_state_t state, state_next;

  logic                 cmd_fire;
  logic                 hc_start, hc_done, hc_level;
  logic [WHOLE_W-1:0]   hc_whole;
  logic [FRACTION_BITS-1:0] hc_frac;
  logic [CH_W-1:0]      hc_ch;
  logic                 div_start, div_done;
  logic [MAG_W-1:0]     div_q;
  logic                 load_out;
  logic                 out_free;
  logic                 out_valid;
  logic [SAMPLE_W-1:0]  out_data;

  // write decode
  logic [BYTE_W-1:0]   wb;
  logic                is_latch, is_write, code_ok, ch_ok;
  logic [CODE_W-1:0]   code;
  logic [LATCH_W-1:0]  code_ch, wr_ch;
  logic [CH_W-1:0]     wr_idx;
  logic                do_latch, do_vol, do_half;
  logic [PERIOD_W-1:0] period_new;
  logic [ATTEN_W-1:0]  atten;
  logic [VOL_W-1:0]    new_vol;

  // mix datapath
  logic [CH_W-1:0]           mix_ch;
  logic signed [TOTAL_W-1:0] total, total_next, contrib, vol_s, mid_s;
  logic                      tot_neg, neg;
  logic [TOTAL_W-1:0]        tot_abs;
  logic [MAG_W-1:0]          mag;
  logic [DIVISOR_W-1:0]      divisor_eff;
  logic [PHASE_W-1:0]        count;
  logic                      stretch, flip;
  logic [CARRY_W-1:0]        carry_new;
  logic [SAMPLE_W-1:0]       sample_val;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate        <= 16'd44100;
      volume_divisor     <= 4'd3;
      exponential_volume <= 1'b1;
      fractional_periods <= 1'b1;
      tuning_offset      <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (psg_reg_t'(cfg.index))
        REG_SAMPLE_RATE:        sample_rate        <= cfg.data[RATE_W-1:0];
        REG_VOLUME_DIVISOR:     volume_divisor     <= cfg.data[DIVISOR_W-1:0];
        REG_EXPONENTIAL_VOLUME: exponential_volume <= cfg.data[0];
        REG_FRACTIONAL_PERIODS: fractional_periods <= cfg.data[0];
        REG_TUNING_OFFSET:      tuning_offset      <= $signed(cfg.data[TUNE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    wb       = cmd.write_byte;
    is_latch = wb[7];
    code     = wb[6:4];
    code_ok  = code < CODE_NOISE;
    code_ch  = CODE_CH_TOP - code[2:1];
    wr_ch    = is_latch ? code_ch : latched_channel;
    ch_ok    = 32'(wr_ch) < TONE_CHANNELS;
    wr_idx   = wr_ch[CH_W-1:0];
    is_write = cmd_fire && !cmd.op;
    do_latch = is_write && is_latch && code_ok && ch_ok;
    do_vol   = do_latch && code[0];
    do_half  = is_write && ch_ok && (is_latch ? (code_ok && !code[0]) : 1'b1);
    period_new = is_latch ? {tone_period[wr_idx][PERIOD_W-1:4], wb[3:0]}
                          : {wb[5:0], tone_period[wr_idx][3:0]};
    atten    = wb[ATTEN_W-1:0];
    new_vol  = level_of(~atten, exponential_volume);
  end

  always_comb begin
    vol_s   = $signed({{(TOTAL_W-VOL_W){1'b0}}, channel_volume[mix_ch]});
    mid_s   = $signed({{(TOTAL_W-VOL_W){1'b0}}, level_of(ATTEN_MID, exponential_volume)});
    if (!channel_active[mix_ch]) begin
      contrib = '0;
    end else if (level_mode[mix_ch]) begin
      contrib = vol_s - mid_s;
    end else if (output_level[mix_ch]) begin
      contrib = vol_s;
    end else begin
      contrib = -vol_s;
    end
    total_next  = total + contrib;
    tot_neg     = total_next[TOTAL_W-1];
    tot_abs     = tot_neg ? TOTAL_W'(-total_next) : TOTAL_W'(total_next);
    mag         = tot_abs[MAG_W+1:2];
    divisor_eff = (volume_divisor == '0) ? DIVISOR_ONE : volume_divisor;
    count       = phase_count[mix_ch] + PHASE_W'(1);
    stretch     = fractional_periods & fraction_carry[mix_ch][FRACTION_BITS];
    flip        = (PHASE_W+1)'(count) >=
                  ((PHASE_W+1)'(half_period_whole[mix_ch]) + (PHASE_W+1)'(stretch));
    carry_new   = {1'b0, fraction_carry[mix_ch][FRACTION_BITS-1:0]} +
                  {1'b0, half_period_fraction[mix_ch]};
    sample_val  = SAMPLE_MID + (neg ? -SAMPLE_W'(div_q) : SAMPLE_W'(div_q));
  end

  psg_half_calc #(.FRACTION_BITS(FRACTION_BITS)) u_half (
    .clk         (clk),
    .rst         (rst),
    .start       (hc_start),
    .period      (period_new),
    .sample_rate (sample_rate),
    .tuning      (tuning_offset),
    .done        (hc_done),
    .whole       (hc_whole),
    .frac        (hc_frac),
    .level_mode  (hc_level)
  );

  psg_serial_div #(.DW(MAG_W), .VW(DIVISOR_W)) u_mix_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (divisor_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free = !out_valid || sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    hc_start   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          if (cmd.op) begin
            state_next = ST_MIX;
          end else if (do_half) begin
            hc_start   = 1'b1;
            state_next = ST_HALF;
          end
        end
      end
      ST_HALF: begin
        if (hc_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_MIX: begin
        if (mix_ch == LAST_CH) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TONE_CHANNELS; i++) begin
        tone_period[i]          <= PERIOD_RESET;
        half_period_whole[i]    <= '0;
        half_period_fraction[i] <= '0;
        fraction_carry[i]       <= '0;
        phase_count[i]          <= '0;
        output_level[i]         <= 1'b0;
        channel_active[i]       <= 1'b0;
        level_mode[i]           <= 1'b0;
        channel_volume[i]       <= VOLUME_RESET;
      end
      latched_channel <= '0;
    end else begin
      if (do_latch) begin
        latched_channel <= wr_ch;
      end
      if (do_vol) begin
        if (channel_volume[wr_idx] == '0 && atten != ATTEN_OFF) begin
          channel_active[wr_idx] <= 1'b1;
        end
        if (channel_volume[wr_idx] != '0 && atten == ATTEN_OFF) begin
          channel_active[wr_idx] <= 1'b0;
        end
        channel_volume[wr_idx] <= new_vol;
      end
      if (do_half) begin
        tone_period[wr_idx] <= period_new;
      end
      if (hc_done) begin
        half_period_whole[hc_ch]    <= hc_whole;
        half_period_fraction[hc_ch] <= hc_frac;
        fraction_carry[hc_ch]       <= {1'b0, hc_frac};
        level_mode[hc_ch]           <= hc_level;
      end
      if (state == ST_MIX && channel_active[mix_ch]) begin
        phase_count[mix_ch] <= flip ? '0 : count;
        if (flip) begin
          fraction_carry[mix_ch] <= carry_new;
          output_level[mix_ch]   <= !output_level[mix_ch];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_half) begin
      hc_ch <= wr_idx;
    end
    if (cmd_fire && cmd.op) begin
      total  <= '0;
      mix_ch <= '0;
    end else if (state == ST_MIX) begin
      total  <= total_next;
      mix_ch <= mix_ch + CH_W'(1);
      if (div_start) begin
        neg <= tot_neg;
      end
    end
    if (load_out) begin
      out_data <= sample_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (sample.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sample.valid        = out_valid;
  assign sample.audio_sample = out_data;

  a_half_state: assert property (@(posedge clk) disable iff (rst) hc_done |-> state == ST_HALF)
    else $error("half-period result outside write state");
  a_div_state: assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIV)
    else $error("mix quotient outside divide state");
  a_tick_mix: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd.op |=> state == ST_MIX)
    else $error("tick transaction did not start mixing");
  a_latch_range: assert property (@(posedge clk) disable iff (rst)
    32'(latched_channel) < TONE_CHANNELS)
    else $error("latched channel out of range");

endmodule

@@ sim/tb.sv @@
// self-checking testbench for the tone register and mixer: directed table, then randomized phases
module tb;
  import psg_pkg::*;

  localparam int NCH = TONE_CHANNELS_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic LATCH = 1'b1;
  localparam logic VOL_SEL = 1'b1;
  localparam logic PERIOD_SEL = 1'b0;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 170;
  localparam int DRAIN_CYCLES = 200;
  localparam int DIRECTED_ROWS = 26;

  typedef struct {
    logic                op;
    logic [BYTE_W-1:0]   wbyte;
    bit                  typed;
    logic [SAMPLE_W-1:0] want;
  } stim_row_t;

  typedef struct {
    logic [RATE_W-1:0]    rate;
    logic [DIVISOR_W-1:0] divisor;
    logic                 expo;
    logic                 frac_on;
    logic [TUNE_W-1:0]    tune;
  } setting_t;

  logic clk = 1'b0;
  logic rst;

  always #4 clk = ~clk;

  psg_in_if  cmd_ch ();
  psg_out_if smp_ch ();
  psg_cfg_if cfg_ch ();

  psg_tone_register_and_mixer DUT (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .sample (smp_ch),
    .cfg    (cfg_ch)
  );

  // predictor copy of configuration and channel state
  logic [RATE_W-1:0]    rate_cfg;
  logic [DIVISOR_W-1:0] div_cfg;
  logic                 expo_cfg;
  logic                 frac_cfg;
  logic [TUNE_W-1:0]    tune_cfg;

  logic [PERIOD_W-1:0] period     [NCH];
  logic [WHOLE_W-1:0]  half_whole [NCH];
  logic [FB-1:0]       half_frac  [NCH];
  logic [FB:0]         carry      [NCH];
  logic [PHASE_W-1:0]  phase      [NCH];
  logic                level      [NCH];
  logic                active     [NCH];
  logic                flat       [NCH];
  logic [VOL_W-1:0]    volume     [NCH];
  logic [LATCH_W-1:0]  latched;

  logic [SAMPLE_W-1:0] sample_q [$];
  logic [SAMPLE_W-1:0] oldest;

  bit idle_on = 1'b1;
  int stall_left = 0;
  int errors = 0;
  int items = 0;
  int ticks = 0;
  int checked = 0;
  int reg_writes = 0;

  stim_row_t directed [DIRECTED_ROWS] = '{
    '{OP_TICK,  8'h00, 1'b1, 8'd128},
    '{OP_WRITE, 8'hE5, 1'b0, 8'd0},
    '{OP_WRITE, 8'hFF, 1'b0, 8'd0},
    '{OP_TICK,  8'h00, 1'b1, 8'd128},
    '{OP_WRITE, 8'h9F, 1'b0, 8'd0},
    '{OP_TICK,  8'h00, 1'b1, 8'd128},
    '{OP_WRITE, 8'h90, 1'b0, 8'd0},
    '{OP_TICK,  8'h00, 1'b1, 8'd118},
    '{OP_TICK,  8'h00, 1'b1, 8'd138},
    '{OP_WRITE, 8'hBF, 1'b0, 8'd0},
    '{OP_WRITE, 8'hB8, 1'b0, 8'd0},
    '{OP_TICK,  8'h00, 1'b0, 8'd0},
    '{OP_WRITE, 8'hA0, 1'b0, 8'd0},
    '{OP_WRITE, 8'h00, 1'b0, 8'd0},
    '{OP_TICK,  8'h00, 1'b0, 8'd0},
    '{OP_WRITE, 8'hCF, 1'b0, 8'd0},
    '{OP_WRITE, 8'h7F, 1'b0, 8'd0},
    '{OP_WRITE, 8'hDF, 1'b0, 8'd0},
    '{OP_WRITE, 8'hD3, 1'b0, 8'd0},
    '{OP_TICK,  8'hFF, 1'b0, 8'd0},
    '{OP_WRITE, 8'h84, 1'b0, 8'd0},
    '{OP_WRITE, 8'h00, 1'b0, 8'd0},
    '{OP_TICK,  8'h00, 1'b0, 8'd0},
    '{OP_WRITE, 8'h85, 1'b0, 8'd0},
    '{OP_TICK,  8'h00, 1'b0, 8'd0},
    '{OP_TICK,  8'h00, 1'b0, 8'd0}
  };

  setting_t fixed_settings [PHASES-1] = '{
    '{16'd44100, 4'd3,  1'b1, 1'b1, 9'h000},
    '{16'd8000,  4'd1,  1'b0, 1'b0, 9'h100},
    '{16'd48000, 4'd15, 1'b1, 1'b1, 9'h0FF},
    '{16'd0,     4'd0,  1'b1, 1'b1, 9'h100},
    '{16'd65535, 4'd1,  1'b0, 1'b1, 9'h0FF},
    '{16'd22050, 4'd7,  1'b1, 1'b0, 9'h1C0}
  };

  function automatic logic [VOL_W-1:0] atten_level(logic [ATTEN_W-1:0] v);
    return expo_cfg ? EXP_LEVELS[v] : VOL_W'({v, 3'b000});
  endfunction

  function automatic void predictor_reset();
    rate_cfg = 16'd44100;
    div_cfg  = 4'd3;
    expo_cfg = 1'b1;
    frac_cfg = 1'b1;
    tune_cfg = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      period[ch]     = PERIOD_RESET;
      half_whole[ch] = '0;
      half_frac[ch]  = '0;
      carry[ch]      = '0;
      phase[ch]      = '0;
      level[ch]      = 1'b0;
      active[ch]     = 1'b0;
      flat[ch]       = 1'b0;
      volume[ch]     = VOLUME_RESET;
    end
    latched = '0;
  endfunction

  function automatic void retune(int ch);
    longint p, freq, h;
    p = (period[ch] == 0) ? 64'd1 : longint'(period[ch]);
    flat[ch] = (p < longint'(LEVEL_MODE_LIMIT));
    freq = CHIP_CLOCK / (32 * p);
    h = (longint'(rate_cfg) << FB) / (2 * freq);
    h += longint'($signed(tune_cfg)) * (longint'(1) << (FB - TUNE_FRAC_BITS));
    if (h < 0) h = 0;
    if ((h >> FB) > longint'(WHOLE_MAX)) begin
      half_whole[ch] = WHOLE_MAX;
      half_frac[ch]  = '1;
    end else begin
      half_whole[ch] = WHOLE_W'(h >> FB);
      half_frac[ch]  = FB'(h);
    end
    carry[ch] = {1'b0, half_frac[ch]};
  endfunction

  function automatic void apply_byte(logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0]  code;
    logic [LATCH_W-1:0] ch;
    logic [ATTEN_W-1:0] att;
    code = b[6:4];
    att  = b[3:0];
    if (!b[7]) begin
      ch = latched;
      if (ch < NCH) begin
        period[ch] = {b[5:0], period[ch][3:0]};
        retune(ch);
      end
      return;
    end
    if (code >= CODE_NOISE) return;
    ch = CODE_CH_TOP - LATCH_W'(code[2:1]);
    if (ch >= NCH) return;
    latched = ch;
    if (code[0]) begin
      if (volume[ch] == 0 && att != ATTEN_OFF) active[ch] = 1'b1;
      if (volume[ch] != 0 && att == ATTEN_OFF) active[ch] = 1'b0;
      volume[ch] = atten_level(ATTEN_OFF - att);
    end else begin
      period[ch] = {period[ch][9:4], att};
      retune(ch);
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] predict_sample();
    int total, divisor, stretch;
    logic [PHASE_W-1:0] nxt;
    total = 0;
    for (int ch = 0; ch < NCH; ch++) begin
      if (!active[ch]) continue;
      if (flat[ch]) total += int'(volume[ch]) - int'(atten_level(ATTEN_MID));
      else if (level[ch]) total += int'(volume[ch]);
      else total -= int'(volume[ch]);
      nxt = phase[ch] + 1'b1;
      stretch = frac_cfg ? int'(carry[ch][FB]) : 0;
      if (int'(nxt) >= int'(half_whole[ch]) + stretch) begin
        carry[ch][FB] = 1'b0;
        carry[ch] = carry[ch] + half_frac[ch];
        nxt = '0;
        level[ch] = ~level[ch];
      end
      phase[ch] = nxt;
    end
    total = total / 4;
    divisor = (div_cfg == 0) ? 1 : int'(div_cfg);
    total = total / divisor;
    return SAMPLE_W'(total + int'(SAMPLE_MID));
  endfunction

  task automatic note_fail(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic put_item(logic op, logic [BYTE_W-1:0] b, bit typed, logic [SAMPLE_W-1:0] want);
    int gap;
    logic [SAMPLE_W-1:0] guess;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.op         <= op;
    cmd_ch.write_byte <= b;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (op == OP_TICK) begin
      guess = predict_sample();
      sample_q.push_back(typed ? want : guess);
      ticks++;
    end else begin
      apply_byte(b);
    end
    if (!(op == OP_WRITE && b[7] && b[6:4] >= CODE_NOISE)) items++;
  endtask

  task automatic drain(int extra);
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(psg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_SAMPLE_RATE:        rate_cfg = d;
      REG_VOLUME_DIVISOR:     div_cfg  = d[DIVISOR_W-1:0];
      REG_EXPONENTIAL_VOLUME: expo_cfg = d[0];
      REG_FRACTIONAL_PERIODS: frac_cfg = d[0];
      REG_TUNING_OFFSET:      tune_cfg = d[TUNE_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(REG_SAMPLE_RATE, s.rate);
    write_reg(REG_VOLUME_DIVISOR, CFG_DATA_W'(s.divisor));
    write_reg(REG_EXPONENTIAL_VOLUME, CFG_DATA_W'(s.expo));
    write_reg(REG_FRACTIONAL_PERIODS, CFG_DATA_W'(s.frac_on));
    write_reg(REG_TUNING_OFFSET, CFG_DATA_W'(s.tune));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      smp_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      smp_ch.ready <= 1'b0;
    end else begin
      smp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && smp_ch.valid && smp_ch.ready) begin
      if (sample_q.size() == 0) begin
        note_fail($sformatf("unexpected audio_sample %0d", smp_ch.audio_sample));
      end else begin
        oldest = sample_q.pop_front();
        checked++;
        if (oldest !== smp_ch.audio_sample)
          note_fail($sformatf("audio_sample mismatch: expected %0d, got %0d",
                              oldest, smp_ch.audio_sample));
      end
    end
  end

  initial begin
    setting_t s;
    int target, pick, n;
    logic [LATCH_W-1:0] code_ch;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.op = OP_WRITE;
    cmd_ch.write_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SAMPLE_RATE;
    cfg_ch.data = '0;
    smp_ch.ready = 1'b0;
    predictor_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      put_item(directed[i].op, directed[i].wbyte, directed[i].typed, directed[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain(DRAIN_CYCLES);
      idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (ph < PHASES - 1) begin
        s = fixed_settings[ph];
      end else begin
        s.rate    = RATE_W'($urandom_range(8000, 48000));
        s.divisor = DIVISOR_W'($urandom);
        s.expo    = 1'($urandom);
        s.frac_on = 1'($urandom);
        s.tune    = TUNE_W'($urandom);
      end
      apply_setting(s);
      target = items + PHASE_ITEMS;
      while (items < target) begin
        pick = $urandom_range(0, 99);
        code_ch = CODE_CH_TOP - LATCH_W'($urandom_range(0, NCH - 1));
        if (pick < 10) begin
          // silence first so that a next attenuation other than off switches the channel on
          put_item(OP_WRITE, {LATCH, code_ch, VOL_SEL, ATTEN_OFF}, 1'b0, '0);
          put_item(OP_WRITE, {LATCH, code_ch, VOL_SEL, 4'($urandom)}, 1'b0, '0);
        end else if (pick < 25) begin
          put_item(OP_WRITE, {LATCH, code_ch, PERIOD_SEL, 4'($urandom)}, 1'b0, '0);
          if ($urandom_range(0, 1))
            put_item(OP_WRITE, {1'b0, 7'($urandom)}, 1'b0, '0);
          else
            put_item(OP_WRITE, {1'b0, 1'($urandom), 6'($urandom_range(0, 3))}, 1'b0, '0);
        end else if (pick < 30) begin
          put_item(OP_WRITE, BYTE_W'($urandom), 1'b0, '0);
        end else if (pick < 32) begin
          drain(0);
        end else begin
          n = $urandom_range(1, 24);
          repeat (n) put_item(OP_TICK, BYTE_W'($urandom), 1'b0, '0);
        end
      end
    end

    drain(DRAIN_CYCLES);
    if (sample_q.size() != 0)
      note_fail($sformatf("%0d expected audio samples never arrived", sample_q.size()));
    $display("%0d transactions sent (%0d ticks), %0d samples checked", items, ticks, checked);
    $display("%0d register writes across %0d settings, extremes included", reg_writes, PHASES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
src/psg_pkg.sv
src/psg_if.sv
src/psg_serial_div.sv
src/psg_half_calc.sv
src/psg_tone_register_and_mixer.sv
sim/tb.sv
